/* sv/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/lzf_pkg.sv */
`timescale 1ns / 1ps

package lzf_pkg;

    // Input item kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Item as it sits in the queue between front and back.
    typedef struct packed {
        logic       is_end;
        logic [7:0] value;
    } queue_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } back_state_t;

endpackage

/* sv/lzf_front.sv */
`timescale 1ns / 1ps

module lzf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [7:0]           byte_value,
    output logic                 q_valid,
    input  logic                 q_ready,
    output lzf_pkg::queue_item_t q_item
);
    import lzf_pkg::*;

    queue_item_t slot_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    queue_item_t item_in;

    always_comb
    begin
        item_in.is_end = (kind == KIND_END);
        item_in.value  = byte_value;
        in_ready  = (cnt_reg != 2'd2);
        q_valid   = (cnt_reg != 2'd0);
        q_item    = slot_reg[rptr_reg];
        push      = in_valid && in_ready;
        pop       = q_valid && q_ready;
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= item_in;
        end
    end

endmodule

/* sv/lzf_back.sv */
`timescale 1ns / 1ps

module lzf_back #(
    parameter int DICT_SIZE = 4096,
    parameter int IW        = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  lzf_pkg::queue_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           extension,
    output logic [IW-1:0]        copy_index,
    output logic                 dict_full,
    output logic                 final_factor
);
    import lzf_pkg::*;

    // Hash table of at least twice the dictionary size, so a probe always
    // ends at a used match or a free slot.
    localparam int AW    = $clog2(DICT_SIZE) + 1;
    localparam int HSIZE = 1 << AW;
    localparam int KW    = IW + 8;
    localparam int NCH   = (KW + AW - 1) / AW;

    typedef struct packed {
        logic          used;
        logic [IW-1:0] prefix;
        logic [7:0]    ch;
        logic [IW-1:0] idx;
    } slot_t;

    slot_t mem [HSIZE];
    slot_t rd_reg;

    back_state_t   state_reg, state_next;
    logic [AW-1:0] probe_reg, probe_next;
    logic [AW-1:0] clr_reg;
    logic [7:0]    byte_reg;
    logic [IW-1:0] count_reg, phrase_reg, parent_reg;
    logic [7:0]    pend_byte_reg;
    logic          pend_valid_reg;
    logic [7:0]    res_ext_reg;
    logic [IW-1:0] res_idx_reg;
    logic          res_full_reg, res_fin_reg, clear_after_reg;
    logic          out_valid_reg;
    logic [7:0]    out_ext_reg;
    logic [IW-1:0] out_idx_reg;
    logic          out_full_reg, out_fin_reg;

    logic          full, hit, out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_data;
    logic [AW-1:0] hash;
    logic [NCH*AW-1:0] key_pad;

    always_comb
    begin
        key_pad = (NCH*AW)'({phrase_reg, q_item.value});
        hash    = '0;
        for (int i = 0; i < NCH; i++)
        begin
            hash = hash ^ key_pad[i*AW +: AW];
        end
    end

    always_comb
    begin
        full     = (count_reg == IW'(DICT_SIZE));
        hit      = rd_reg.used && (rd_reg.prefix == phrase_reg) && (rd_reg.ch == byte_reg);
        out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(HSIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.is_end)
                    begin
                        state_next = pend_valid_reg ? ST_EMIT : ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!rd_reg.used)
                begin
                    state_next = ST_EMIT;
                end
                else if (hit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = clear_after_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        q_ready    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = probe_reg;
        wr_data    = '0;
        probe_next = probe_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            ST_IDLE:
            begin
                q_ready    = 1'b1;
                probe_next = hash;
            end
            ST_CMP:
            begin
                if (!rd_reg.used)
                begin
                    wr_en          = !full;
                    wr_data.used   = 1'b1;
                    wr_data.prefix = phrase_reg;
                    wr_data.ch     = byte_reg;
                    wr_data.idx    = count_reg + IW'(1);
                end
                else if (!hit)
                begin
                    probe_next = probe_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[probe_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            probe_reg       <= '0;
            clr_reg         <= '0;
            byte_reg        <= '0;
            count_reg       <= '0;
            phrase_reg      <= '0;
            parent_reg      <= '0;
            pend_byte_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            res_ext_reg     <= '0;
            res_idx_reg     <= '0;
            res_full_reg    <= 1'b0;
            res_fin_reg     <= 1'b0;
            clear_after_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_ext_reg     <= '0;
            out_idx_reg     <= '0;
            out_full_reg    <= 1'b0;
            out_fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            probe_reg <= probe_next;
            clr_reg   <= (state_reg == ST_CLEAR) ? clr_reg + AW'(1) : '0;

            if (state_reg == ST_IDLE && q_valid)
            begin
                byte_reg <= q_item.value;
                if (q_item.is_end)
                begin
                    // The flush factor carries the last matched byte and its prefix.
                    res_ext_reg     <= pend_byte_reg;
                    res_idx_reg     <= parent_reg;
                    res_full_reg    <= 1'b0;
                    res_fin_reg     <= 1'b1;
                    clear_after_reg <= 1'b1;
                    count_reg       <= '0;
                    phrase_reg      <= '0;
                    parent_reg      <= '0;
                    pend_byte_reg   <= '0;
                    pend_valid_reg  <= 1'b0;
                end
            end

            if (state_reg == ST_CMP)
            begin
                if (!rd_reg.used)
                begin
                    res_ext_reg     <= byte_reg;
                    res_idx_reg     <= phrase_reg;
                    res_full_reg    <= full;
                    res_fin_reg     <= 1'b0;
                    clear_after_reg <= 1'b0;
                    if (!full)
                    begin
                        count_reg <= count_reg + IW'(1);
                    end
                    phrase_reg     <= '0;
                    parent_reg     <= '0;
                    pend_byte_reg  <= '0;
                    pend_valid_reg <= 1'b0;
                end
                else if (hit)
                begin
                    parent_reg     <= phrase_reg;
                    phrase_reg     <= rd_reg.idx;
                    pend_byte_reg  <= byte_reg;
                    pend_valid_reg <= 1'b1;
                end
            end

            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_ext_reg   <= res_ext_reg;
                out_idx_reg   <= res_idx_reg;
                out_full_reg  <= res_full_reg;
                out_fin_reg   <= res_fin_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign extension    = out_ext_reg;
    assign copy_index   = out_idx_reg;
    assign dict_full    = out_full_reg;
    assign final_factor = out_fin_reg;

endmodule

/* sv/lz78_factor_encoder.sv */
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_ready  kind, byte_value
// out      out_valid / out_ready extension, copy_index, dict_full, final_factor
//
// A data byte probes on from its hash, one slot per collision, to a hit or a free slot.
// The lookup is one read of the hash table per probe, and each byte waits on the last.
// An end item sends a flush factor if a match is pending; then the whole hash table
// is cleared; the same clear runs after reset, and the back end takes no item meanwhile.
// A two-item queue takes input while the back end works or waits on out_ready.
module lz78_factor_encoder #(
    parameter int DICT_SIZE = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           kind,
    input  logic [7:0]                     byte_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     extension,
    output logic [$clog2(DICT_SIZE+1)-1:0] copy_index,
    output logic                           dict_full,
    output logic                           final_factor
);
    import lzf_pkg::*;

    localparam int IW = $clog2(DICT_SIZE + 1);

    logic        q_valid, q_ready;
    queue_item_t q_item;

    lzf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    lzf_back #(
        .DICT_SIZE (DICT_SIZE),
        .IW        (IW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .extension    (extension),
        .copy_index   (copy_index),
        .dict_full    (dict_full),
        .final_factor (final_factor)
    );

endmodule

/* sv/lzf_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzf_checker #(
    parameter int DICT_SIZE = 4096
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [7:0]                     extension,
    input logic [$clog2(DICT_SIZE+1)-1:0] copy_index,
    input logic                           dict_full,
    input logic                           final_factor
);
    localparam int IW = $clog2(DICT_SIZE + 1);

    logic [IW+9:0] payload;

    assign payload = {extension, copy_index, dict_full, final_factor};

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(payload))
    `ASSERT_NOW(a_flush_not_full, clk, rst_n, out_valid && final_factor, !dict_full)
    `ASSERT_NOW(a_index_range, clk, rst_n, out_valid, copy_index <= IW'(DICT_SIZE))

endmodule

bind lz78_factor_encoder lzf_checker #(.DICT_SIZE(DICT_SIZE)) u_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import lzf_pkg::*;

    localparam int DICT_SIZE = 4096;
    localparam int IW = $clog2(DICT_SIZE + 1);
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic [7:0]    ext;
        logic [IW-1:0] idx;
        logic          full;
        logic          fin;
    } factor_t;

    typedef struct {
        logic    k;
        logic [7:0] b;
        bit      typed;
        bit      has_factor;
        factor_t f;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic          kind;
    logic [7:0]    byte_value;
    logic          out_valid;
    logic          out_ready;
    logic [7:0]    extension;
    logic [IW-1:0] copy_index;
    logic          dict_full;
    logic          final_factor;

    lz78_factor_encoder #(.DICT_SIZE(DICT_SIZE)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .byte_value(byte_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .extension(extension),
        .copy_index(copy_index),
        .dict_full(dict_full),
        .final_factor(final_factor)
    );

    // Encoder state kept by the testbench.
    int         phrase_map[int];
    int         n_entries;
    int         cur_phrase;
    int         cur_parent;
    logic [7:0] held_byte;
    bit         held_valid;

    factor_t    factor_q[$];
    int         n_errors;
    int         n_items;
    int         n_factors;
    int         n_flush;
    int         n_full;
    bit         idle_in;
    bit         idle_out;
    int         stall_count;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bit next_factor(input logic k, input logic [7:0] b,
                                       output factor_t f);
        int key;
        f = '0;
        if (k == KIND_END) begin
            bit got;
            got = held_valid;
            f.ext = held_byte;
            f.idx = cur_parent[IW-1:0];
            f.fin = 1'b1;
            phrase_map.delete();
            n_entries = 0;
            cur_phrase = 0;
            cur_parent = 0;
            held_byte = '0;
            held_valid = 0;
            return got;
        end
        key = cur_phrase * 256 + b;
        if (phrase_map.exists(key)) begin
            cur_parent = cur_phrase;
            cur_phrase = phrase_map[key];
            held_byte = b;
            held_valid = 1;
            return 0;
        end
        f.ext = b;
        f.idx = cur_phrase[IW-1:0];
        f.full = (n_entries >= DICT_SIZE);
        if (!f.full) begin
            n_entries++;
            phrase_map[key] = n_entries;
        end
        cur_phrase = 0;
        cur_parent = 0;
        held_byte = '0;
        held_valid = 0;
        return 1;
    endfunction

    task automatic send_item(input logic k, input logic [7:0] b, input bit typed,
                             input bit typed_has, input factor_t tf);
        int gap;
        factor_t f;
        bit got;
        gap = idle_in ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        byte_value <= b;
        do @(posedge clk); while (!in_ready);
        n_items++;
        got = next_factor(k, b, f);
        if (typed) begin
            got = typed_has;
            f = tf;
        end
        if (got) factor_q.push_back(f);
    endtask

    task automatic send_rand(input logic k, input logic [7:0] b);
        send_item(k, b, 0, 0, '0);
    endtask

    task automatic drain_factors();
        in_valid <= 1'b0;
        while (factor_q.size() > 0) @(posedge clk);
    endtask

    // Output side: random back-pressure, checks every factor in order.
    initial begin
        int gap;
        factor_t want;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            gap = idle_out ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            n_factors++;
            if (final_factor) n_flush++;
            if (dict_full) n_full++;
            if (factor_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected factor ext=%h idx=%0d full=%b fin=%b",
                             extension, copy_index, dict_full, final_factor);
            end else begin
                want = factor_q.pop_front();
                if (want.ext !== extension || want.idx !== copy_index ||
                    want.full !== dict_full || want.fin !== final_factor) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"factor %0d: exp ext=%h idx=%0d full=%b fin=%b,",
                                  " got ext=%h idx=%0d full=%b fin=%b"},
                                 n_factors, want.ext, want.idx, want.full, want.fin,
                                 extension, copy_index, dict_full, final_factor);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("lz78_factor_encoder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        logic [7:0] alpha[4];
        factor_t scratch;
        int na;
        int len;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_DATA;
        byte_value <= '0;
        idle_in = 1;
        idle_out = 1;
        n_errors = 0;
        n_items = 0;
        n_factors = 0;
        n_flush = 0;
        n_full = 0;
        void'(next_factor(KIND_END, '0, scratch));
        factor_q.delete();

        // Directed rows; typed factors follow the dictionary by hand.
        rows.push_back('{KIND_DATA, 8'h00, 1, 1, '{8'h00, 0, 0, 0}});
        rows.push_back('{KIND_DATA, 8'hFF, 1, 1, '{8'hFF, 0, 0, 0}});
        rows.push_back('{KIND_DATA, 8'h00, 1, 0, '0});
        rows.push_back('{KIND_DATA, 8'hFF, 1, 1, '{8'hFF, 1, 0, 0}});
        rows.push_back('{KIND_DATA, 8'h00, 1, 0, '0});
        rows.push_back('{KIND_END, 8'hFF, 1, 1, '{8'h00, 0, 0, 1}});
        rows.push_back('{KIND_END, 8'h00, 1, 0, '0});
        rows.push_back('{KIND_DATA, 8'h41, 1, 1, '{8'h41, 0, 0, 0}});
        rows.push_back('{KIND_DATA, 8'h41, 1, 0, '0});
        rows.push_back('{KIND_DATA, 8'h41, 1, 1, '{8'h41, 1, 0, 0}});
        rows.push_back('{KIND_DATA, 8'h41, 1, 0, '0});
        rows.push_back('{KIND_DATA, 8'h41, 1, 0, '0});
        rows.push_back('{KIND_END, 8'h00, 1, 1, '{8'h41, 1, 0, 1}});
        rows.push_back('{KIND_DATA, 8'h80, 0, 0, '0});
        rows.push_back('{KIND_DATA, 8'h7F, 0, 0, '0});
        rows.push_back('{KIND_DATA, 8'h80, 0, 0, '0});
        rows.push_back('{KIND_DATA, 8'h7F, 0, 0, '0});
        rows.push_back('{KIND_DATA, 8'h80, 0, 0, '0});
        rows.push_back('{KIND_DATA, 8'h7F, 0, 0, '0});
        rows.push_back('{KIND_DATA, 8'h01, 0, 0, '0});
        rows.push_back('{KIND_END, 8'hAA, 0, 0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_item(rows[i].k, rows[i].b, rows[i].typed, rows[i].has_factor, rows[i].f);

        // Hold the input back until every factor so far has come out.
        drain_factors();

        // Short streams over small alphabets so phrases grow, with some noise.
        while (n_items < 1120) begin
            if ($urandom_range(0, 7) == 0) begin
                idle_in = 1'($urandom_range(0, 1));
                idle_out = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 15) == 0) drain_factors();
            na = $urandom_range(1, 4);
            foreach (alpha[j]) alpha[j] = 8'($urandom_range(0, 255));
            len = $urandom_range(1, 60);
            repeat (len) begin
                if ($urandom_range(0, 9) == 0)
                    send_rand(KIND_DATA, 8'($urandom_range(0, 255)));
                else
                    send_rand(KIND_DATA, alpha[$urandom_range(0, na - 1)]);
            end
            if ($urandom_range(0, 5) != 0) send_rand(KIND_END, 8'($urandom_range(0, 255)));
        end

        idle_in = 1;
        idle_out = 1;
        send_rand(KIND_END, 8'h00);
        repeat (20) send_rand(KIND_DATA, 8'($urandom_range(0, 255)));
        send_rand(KIND_END, 8'h00);

        drain_factors();
        repeat (50) @(posedge clk);
        $display("Sent %0d items and checked %0d factors, %0d of them flushes.",
                 n_items, n_factors, n_flush);
        $display("Streams of varied length over small alphabets ran under random stalls;"
                 , " %0d factors came with the dictionary full.", n_full);
        if (n_errors == 0 && factor_q.size() == 0)
            $display("lz78_factor_encoder: match");
        else
            $display("lz78_factor_encoder: mismatch");
        $finish;
    end

endmodule
